// File: hw/rtl/cphd_pkg.sv
// Shared types and register codes for the column peak-hold tracker.
package cphd_pkg;

   localparam int unsigned COLUMN_CODES = 32;

   localparam logic [3:0] CSR_ROWS_IN_USE   = 4'd0;
   localparam logic [3:0] CSR_MAX_FALL_WAIT = 4'd1;
   localparam logic [3:0] CSR_FALL_STEP     = 4'd2;
   localparam logic [3:0] CSR_PEAK_COLOUR   = 4'd3;

   localparam logic [4:0]  RESET_ROWS_IN_USE   = 5'd16;
   localparam logic [15:0] RESET_MAX_FALL_WAIT = 16'd1500;
   localparam logic [15:0] RESET_FALL_STEP     = 16'd25;
   localparam logic [23:0] RESET_PEAK_COLOUR   = 24'hFFFFFF;

   typedef struct packed {
      logic [3:0]  peak_row;
      logic [31:0] last_fall_time;
      logic [15:0] current_wait;
   } col_state_type;

endpackage

// File: hw/rtl/cphd_if.sv
// Channel interfaces for the column peak-hold tracker.
interface cphd_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  column;
   logic [4:0]  level;
   logic [31:0] now_ms;
   modport source (output valid, column, level, now_ms, input ready);
   modport sink (input valid, column, level, now_ms, output ready);
endinterface

interface cphd_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  led_index;
   logic [23:0] pixel_colour;
   logic [3:0]  peak_after;
   modport source (output valid, led_index, pixel_colour, peak_after, input ready);
   modport sink (input valid, led_index, pixel_colour, peak_after, output ready);
endinterface

interface cphd_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/column_peak_hold_decay.sv
// Top level of the column peak-hold tracker with accelerating decay.
// Channels: req_chan carries column, level and now_ms; rsp_chan returns
// led_index, pixel_colour and peak_after, one result per request; csr_chan
// writes rows_in_use, max_fall_wait, fall_step and peak_colour by index.
// A request transfer issues a read of that column's state from the state
// memory; when the update stage advances, it updates peak, fall time and
// wait, writes them back and loads the output register, which drives
// rsp_chan.valid. Throughput is one request per cycle while rsp_chan does
// not stall: the memory read delay is covered by forwarding the entry
// written in the same cycle as the read, so back-to-back hits on one column
// work.
// Reset clears the configuration to its defaults and marks every column
// entry invalid, so it reads as zero until first written; no clearing pass.
// When rsp_chan stalls, the output register holds its result, one more
// request is taken into the update stage, and req_chan.ready then drops
// until the output register drains.
module column_peak_hold_decay #(
   parameter int COLUMNS = 32,
   parameter int ROWS    = 16
) (
   input logic         clock,
   input logic         reset,
   cphd_req_if.sink    req_chan,
   cphd_rsp_if.source  rsp_chan,
   cphd_csr_if.sink    csr_chan
);

   localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam logic [4:0] ROWS_CAP = 5'((ROWS > 31) ? 31 : ROWS);

   logic [4:0]  rows_in_use_ff;
   logic [15:0] max_fall_wait_ff;
   logic [15:0] fall_step_ff;
   logic [23:0] peak_colour_ff;

   cphd_pkg::col_state_type state_mem_ff [COLUMNS];
   logic                    entry_valid_ff [COLUMNS];
   cphd_pkg::col_state_type rd_data_ff;
   logic                    rd_valid_ff;
   logic                    fwd_hit_ff;
   cphd_pkg::col_state_type fwd_data_ff;

   logic          s1_valid_ff;
   logic [CW-1:0] s1_col_ff;
   logic [4:0]    s1_level_ff;
   logic [31:0]   s1_now_ff;

   logic          rsp_valid_ff;
   logic [8:0]    led_index_ff;
   logic [23:0]   pixel_colour_ff;
   logic [3:0]    peak_after_ff;

   logic [CW-1:0] col_map [cphd_pkg::COLUMN_CODES];
   logic [CW-1:0] req_col;
   logic          req_xfer;
   logic          s1_adv;

   cphd_pkg::col_state_type cur_state;
   cphd_pkg::col_state_type new_state;
   logic [4:0]    rows_eff;
   logic [4:0]    top_wide;
   logic [3:0]    top_row;
   logic [3:0]    peak_mid;
   logic [31:0]   last_mid;
   logic [15:0]   wait_mid;
   logic [31:0]   elapsed;
   logic          fall;
   logic [15:0]   wait_sub;
   logic [CW+4:0] col_base;
   logic [8:0]    led_in;
   logic [23:0]   colour_in;

   // column modulo table
   for (genvar i = 0; i < cphd_pkg::COLUMN_CODES; i++) begin : g_col_map
      localparam int MAPPED = i % COLUMNS;
      assign col_map[i] = CW'(MAPPED);
   end

   assign req_col  = col_map[req_chan.column];
   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff   <= cphd_pkg::RESET_ROWS_IN_USE;
         max_fall_wait_ff <= cphd_pkg::RESET_MAX_FALL_WAIT;
         fall_step_ff     <= cphd_pkg::RESET_FALL_STEP;
         peak_colour_ff   <= cphd_pkg::RESET_PEAK_COLOUR;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            cphd_pkg::CSR_ROWS_IN_USE:   rows_in_use_ff   <= csr_chan.data[4:0];
            cphd_pkg::CSR_MAX_FALL_WAIT: max_fall_wait_ff <= csr_chan.data[15:0];
            cphd_pkg::CSR_FALL_STEP:     fall_step_ff     <= csr_chan.data[15:0];
            cphd_pkg::CSR_PEAK_COLOUR:   peak_colour_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // state memory: read on request transfer, write on stage advance
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         state_mem_ff[s1_col_ff] <= new_state;
      end
      if (req_xfer) begin
         rd_data_ff <= state_mem_ff[req_col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COLUMNS; i++) begin
            entry_valid_ff[i] <= 1'b0;
         end
      end else if (s1_adv) begin
         entry_valid_ff[s1_col_ff] <= 1'b1;
      end
   end

   // update stage and forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
            rd_valid_ff <= entry_valid_ff[req_col];
            fwd_hit_ff  <= s1_adv && (s1_col_ff == req_col);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_col_ff   <= req_col;
         s1_level_ff <= req_chan.level;
         s1_now_ff   <= req_chan.now_ms;
         fwd_data_ff <= new_state;
      end
   end

   always_comb begin
      if (fwd_hit_ff) begin
         cur_state = fwd_data_ff;
      end else if (rd_valid_ff) begin
         cur_state = rd_data_ff;
      end else begin
         cur_state = '0;
      end

      if (rows_in_use_ff == 5'd0) begin
         rows_eff = 5'd1;
      end else if (rows_in_use_ff > ROWS_CAP) begin
         rows_eff = ROWS_CAP;
      end else begin
         rows_eff = rows_in_use_ff;
      end
      top_wide = rows_eff - 5'd1;
      top_row  = (top_wide > 5'd15) ? 4'd15 : top_wide[3:0];

      if (s1_level_ff > {1'b0, cur_state.peak_row}) begin
         peak_mid = (s1_level_ff > {1'b0, top_row}) ? top_row : s1_level_ff[3:0];
         last_mid = s1_now_ff;
         wait_mid = max_fall_wait_ff;
      end else begin
         peak_mid = cur_state.peak_row;
         last_mid = cur_state.last_fall_time;
         wait_mid = cur_state.current_wait;
      end

      col_base  = s1_col_ff * rows_eff;
      led_in    = 9'(col_base) + 9'(peak_mid);
      colour_in = (peak_mid != 4'd0) ? peak_colour_ff : 24'd0;

      elapsed = s1_now_ff - last_mid;
      fall    = (elapsed >= {16'd0, wait_mid}) && (peak_mid != 4'd0);

      wait_sub = (wait_mid > fall_step_ff) ? (wait_mid - fall_step_ff) : 16'd0;

      new_state.peak_row       = fall ? (peak_mid - 4'd1) : peak_mid;
      new_state.last_fall_time = fall ? s1_now_ff : last_mid;
      new_state.current_wait   = (wait_sub < fall_step_ff) ? fall_step_ff : wait_sub;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         led_index_ff    <= led_in;
         pixel_colour_ff <= colour_in;
         peak_after_ff   <= new_state.peak_row;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.led_index    = led_index_ff;
   assign rsp_chan.pixel_colour = pixel_colour_ff;
   assign rsp_chan.peak_after   = peak_after_ff;

   a_fwd_after_write: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !s1_adv) |=> !fwd_hit_ff)
      else $error("forward hit without a write at the read");

   a_no_take_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !req_chan.ready)
      else $error("request taken while update stage is stalled");

   a_adv_loads_output: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced result missing from output register");

endmodule
